// File: sv/sequential_list_engine_macros.svh
// Assertion macros used by the list engine datapath.
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// Check that holds in the same cycle as its precondition.
`define SLE_ASSERT_NOW(lbl, pre, chk, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (chk)) \
        else $error(msg);

// Check that holds in the cycle after its precondition.
`define SLE_ASSERT_NEXT(lbl, pre, chk, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (chk)) \
        else $error(msg);

`endif

// File: sv/sle_pkg.sv
// Types, constants and the control store of the list engine.
package sle_pkg;

    // Default sizes of the store.
    localparam int DEF_CAPACITY  = 128;
    localparam int DEF_WORD_BITS = 32;

    // Fixed field widths of the request and response words.
    localparam int KIND_BITS   = 2;
    localparam int VALUE_BITS  = 32;
    localparam int POS_BITS    = 7;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 8;
    localparam int UPC_BITS    = 5;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_APPEND  = 2'd0,
        KIND_DELETE  = 2'd1,
        KIND_REVERSE = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2
    } status_t;

    // Jump conditions of the sequencer.
    typedef enum logic [2:0] {
        C_NEXT    = 3'd0,
        C_ALWAYS  = 3'd1,
        C_FULL    = 3'd2,
        C_BAD_POS = 3'd3,
        C_DEL_END = 3'd4,
        C_SHORT   = 3'd5,
        C_REV_END = 3'd6
    } cond_t;

    typedef enum logic [1:0] {
        A_HOLD = 2'd0,
        A_POS  = 2'd1,
        A_ZERO = 2'd2,
        A_INC  = 2'd3
    } a_op_t;

    typedef enum logic [1:0] {
        B_HOLD = 2'd0,
        B_LOAD = 2'd1,
        B_DEC  = 2'd2
    } b_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    typedef enum logic [1:0] {
        RA_A      = 2'd0,
        RA_A_NEXT = 2'd1,
        RA_B      = 2'd2,
        RA_POS    = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_CNT = 2'd0,
        WA_A   = 2'd1,
        WA_B   = 2'd2
    } wr_sel_t;

    typedef enum logic [1:0] {
        WD_VALUE = 2'd0,
        WD_RDATA = 2'd1,
        WD_TMP   = 2'd2
    } wdata_sel_t;

    typedef logic [UPC_BITS-1:0] upc_t;

    // Step addresses of the microprogram.
    localparam upc_t U_IDLE = 5'd0;
    localparam upc_t U_EMIT = 5'd1;
    localparam upc_t U_BADP = 5'd2;
    localparam upc_t U_FULL = 5'd3;
    localparam upc_t U_A0   = 5'd4;
    localparam upc_t U_A1   = 5'd5;
    localparam upc_t U_D0   = 5'd6;
    localparam upc_t U_D1   = 5'd7;
    localparam upc_t U_D2   = 5'd8;
    localparam upc_t U_DFIN = 5'd9;
    localparam upc_t U_R0   = 5'd10;
    localparam upc_t U_R1   = 5'd11;
    localparam upc_t U_R2   = 5'd12;
    localparam upc_t U_R3   = 5'd13;
    localparam upc_t U_R4   = 5'd14;
    localparam upc_t U_Q0   = 5'd15;
    localparam upc_t U_Q1   = 5'd16;
    localparam upc_t U_Q2   = 5'd17;

    // One control word of the microprogram.
    typedef struct packed {
        logic       idle;
        logic       emit;
        cond_t      cond;
        upc_t       target;
        a_op_t      a_op;
        b_op_t      b_op;
        cnt_op_t    cnt_op;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        wr_sel_t    wr_addr;
        wdata_sel_t wr_data;
        logic       tmp_ld;
        logic       rdv_ld;
        logic       st_ld;
        status_t    st_code;
    } uword_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic  req_fire;
        kind_t req_kind;
        logic  out_free;
        logic  full;
        logic  bad_pos;
        logic  del_end;
        logic  short_list;
        logic  rev_end;
    } dp_flags_t;

    // Entry step for each request kind.
    function automatic upc_t entry_of(kind_t k);
        upc_t pc;
        unique case (k)
            KIND_APPEND:  pc = U_A0;
            KIND_DELETE:  pc = U_D0;
            KIND_REVERSE: pc = U_R0;
            KIND_READ:    pc = U_Q0;
            default:      pc = U_IDLE;
        endcase
        return pc;
    endfunction

    // Read-only control store.
    function automatic uword_t ucode(upc_t pc);
        uword_t w;
        w = '0;
        unique case (pc)
            U_IDLE:
            begin
                w.idle = 1'b1;
            end
            U_EMIT:
            begin
                w.emit = 1'b1;
            end
            U_BADP:
            begin
                w.st_ld   = 1'b1;
                w.st_code = ST_BAD_POS;
                w.cond    = C_ALWAYS;
                w.target  = U_EMIT;
            end
            U_FULL:
            begin
                w.st_ld   = 1'b1;
                w.st_code = ST_FULL;
                w.cond    = C_ALWAYS;
                w.target  = U_EMIT;
            end
            U_A0:
            begin
                w.cond   = C_FULL;
                w.target = U_FULL;
            end
            U_A1:
            begin
                w.wr_en   = 1'b1;
                w.wr_addr = WA_CNT;
                w.wr_data = WD_VALUE;
                w.cnt_op  = CNT_INC;
                w.cond    = C_ALWAYS;
                w.target  = U_EMIT;
            end
            U_D0:
            begin
                w.a_op   = A_POS;
                w.cond   = C_BAD_POS;
                w.target = U_BADP;
            end
            U_D1:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RA_A_NEXT;
                w.cond   = C_DEL_END;
                w.target = U_DFIN;
            end
            U_D2:
            begin
                w.wr_en   = 1'b1;
                w.wr_addr = WA_A;
                w.wr_data = WD_RDATA;
                w.a_op    = A_INC;
                w.cond    = C_ALWAYS;
                w.target  = U_D1;
            end
            U_DFIN:
            begin
                w.cnt_op = CNT_DEC;
                w.cond   = C_ALWAYS;
                w.target = U_EMIT;
            end
            U_R0:
            begin
                w.a_op   = A_ZERO;
                w.b_op   = B_LOAD;
                w.cond   = C_SHORT;
                w.target = U_EMIT;
            end
            U_R1:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RA_A;
                w.cond   = C_REV_END;
                w.target = U_EMIT;
            end
            U_R2:
            begin
                w.tmp_ld = 1'b1;
                w.rd_en  = 1'b1;
                w.rd_sel = RA_B;
            end
            U_R3:
            begin
                w.wr_en   = 1'b1;
                w.wr_addr = WA_A;
                w.wr_data = WD_RDATA;
            end
            U_R4:
            begin
                w.wr_en   = 1'b1;
                w.wr_addr = WA_B;
                w.wr_data = WD_TMP;
                w.a_op    = A_INC;
                w.b_op    = B_DEC;
                w.cond    = C_ALWAYS;
                w.target  = U_R1;
            end
            U_Q0:
            begin
                w.cond   = C_BAD_POS;
                w.target = U_BADP;
            end
            U_Q1:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RA_POS;
            end
            U_Q2:
            begin
                w.rdv_ld = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = U_EMIT;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: sv/sle_in_if.sv
// Request channel: valid/ready handshake carrying one request word.
interface sle_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [sle_pkg::KIND_BITS-1:0]        kind;
    logic signed [sle_pkg::VALUE_BITS-1:0] value;
    logic [sle_pkg::POS_BITS-1:0]         position;

    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

// File: sv/sle_out_if.sv
// Response channel: valid/ready handshake carrying one response word.
interface sle_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [sle_pkg::STATUS_BITS-1:0]       status;
    logic [sle_pkg::COUNT_BITS-1:0]        count_after;
    logic signed [sle_pkg::VALUE_BITS-1:0] read_value;

    modport source (output valid, status, count_after, read_value, input ready);
    modport sink   (input valid, status, count_after, read_value, output ready);
endinterface

// File: sv/sle_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
module sle_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  sle_pkg::dp_flags_t flags,
    output sle_pkg::uword_t    ctl
);
    import sle_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic cond_true;

    // Control word of the current step.
    assign ctl = ucode(upc_reg);

    // Evaluate the jump condition of the current step.
    always_comb
    begin
        unique case (ctl.cond)
            C_NEXT:    cond_true = 1'b0;
            C_ALWAYS:  cond_true = 1'b1;
            C_FULL:    cond_true = flags.full;
            C_BAD_POS: cond_true = flags.bad_pos;
            C_DEL_END: cond_true = flags.del_end;
            C_SHORT:   cond_true = flags.short_list;
            C_REV_END: cond_true = flags.rev_end;
            default:   cond_true = 1'b0;
        endcase
    end

    // Idle waits for a request, emit waits for a free output slot.
    always_comb
    begin
        priority if (ctl.idle)
        begin
            upc_next = flags.req_fire ? entry_of(flags.req_kind) : upc_reg;
        end
        else if (ctl.emit)
        begin
            upc_next = flags.out_free ? U_IDLE : upc_reg;
        end
        else if (cond_true)
        begin
            upc_next = ctl.target;
        end
        else
        begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: sv/sle_dp.sv
// List datapath: entry memory, index and count registers, response register.
`include "sequential_list_engine_macros.svh"

module sle_dp #(
    parameter int CAPACITY  = sle_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = sle_pkg::DEF_WORD_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sle_pkg::uword_t    ctl,
    output sle_pkg::dp_flags_t flags,
    sle_in_if.sink             req,
    sle_out_if.source          rsp
);
    import sle_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

    // Entry store.
    logic [WORD_BITS-1:0] mem [CAPACITY];

    // Latched request.
    logic signed [VALUE_BITS-1:0] value_reg;
    logic [POS_BITS-1:0]          pos_reg;

    // Walk indexes, length and scratch words.
    logic [AW-1:0]         a_reg, a_next;
    logic [AW-1:0]         b_reg, b_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [WORD_BITS-1:0]  tmp_reg;
    logic [WORD_BITS-1:0]  rdata_reg;
    status_t               status_reg;
    logic [VALUE_BITS-1:0] rdv_reg;

    // Response register.
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [VALUE_BITS-1:0] out_rdv_reg;

    logic                        req_fire;
    logic                        out_load;
    logic [CW-1:0]               a_plus1;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic [WORD_BITS-1:0]        wr_word;
    logic [63:0]                 val_ext;
    logic signed [WORD_BITS-1:0] rdata_s;
    logic signed [63:0]          rdata_ext;

    // Handshake: requests only in the idle step, responses from the output register.
    assign req.ready = ctl.idle;
    assign req_fire  = req.valid && req.ready;
    assign out_load  = ctl.emit && flags.out_free;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.count_after = out_count_reg;
    assign rsp.read_value  = out_rdv_reg;

    assign a_plus1   = CW'(a_reg) + CW'(1);
    assign val_ext   = {{(64 - VALUE_BITS){value_reg[VALUE_BITS-1]}}, value_reg};
    assign rdata_s   = rdata_reg;
    assign rdata_ext = 64'(rdata_s);

    // Status flags for the sequencer.
    always_comb
    begin
        flags.req_fire   = req_fire;
        flags.req_kind   = kind_t'(req.kind);
        flags.out_free   = !out_valid_reg || rsp.ready;
        flags.full       = (cnt_reg == CW'(CAPACITY));
        flags.bad_pos    = (CMPW'(pos_reg) >= CMPW'(cnt_reg));
        flags.del_end    = (a_plus1 >= cnt_reg);
        flags.short_list = (cnt_reg < CW'(2));
        flags.rev_end    = (a_reg >= b_reg);
    end

    // Memory read address.
    always_comb
    begin
        unique case (ctl.rd_sel)
            RA_A:      rd_addr = a_reg;
            RA_A_NEXT: rd_addr = AW'(a_plus1);
            RA_B:      rd_addr = b_reg;
            RA_POS:    rd_addr = AW'(pos_reg);
            default:   rd_addr = a_reg;
        endcase
    end

    // Memory write address and data.
    always_comb
    begin
        unique case (ctl.wr_addr)
            WA_CNT:  wr_addr = AW'(cnt_reg);
            WA_A:    wr_addr = a_reg;
            WA_B:    wr_addr = b_reg;
            default: wr_addr = a_reg;
        endcase
        unique case (ctl.wr_data)
            WD_VALUE: wr_word = val_ext[WORD_BITS-1:0];
            WD_RDATA: wr_word = rdata_reg;
            WD_TMP:   wr_word = tmp_reg;
            default:  wr_word = rdata_reg;
        endcase
    end

    // Index and count updates.
    always_comb
    begin
        unique case (ctl.a_op)
            A_HOLD:  a_next = a_reg;
            A_POS:   a_next = AW'(pos_reg);
            A_ZERO:  a_next = '0;
            A_INC:   a_next = a_reg + AW'(1);
            default: a_next = a_reg;
        endcase
        unique case (ctl.b_op)
            B_HOLD:  b_next = b_reg;
            B_LOAD:  b_next = AW'(cnt_reg - CW'(1));
            B_DEC:   b_next = b_reg - AW'(1);
            default: b_next = b_reg;
        endcase
        unique case (ctl.cnt_op)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_INC:  cnt_next = cnt_reg + CW'(1);
            CNT_DEC:  cnt_next = cnt_reg - CW'(1);
            default:  cnt_next = cnt_reg;
        endcase
    end

    // Entry memory with registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Control state: length and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (req_fire)
        begin
            value_reg  <= req.value;
            pos_reg    <= req.position;
            status_reg <= ST_OK;
            rdv_reg    <= '0;
        end
        else
        begin
            if (ctl.st_ld)
            begin
                status_reg <= ctl.st_code;
            end
            if (ctl.rdv_ld)
            begin
                rdv_reg <= rdata_ext[VALUE_BITS-1:0];
            end
        end
        if (ctl.tmp_ld)
        begin
            tmp_reg <= rdata_reg;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_BITS'(cnt_reg);
            out_rdv_reg    <= rdv_reg;
        end
    end

    // The length never passes the capacity.
    `SLE_ASSERT_NOW(a_cnt_cap, 1'b1, cnt_reg <= CW'(CAPACITY), "length above capacity")
    // Writes land inside the list or just past its end on append.
    `SLE_ASSERT_NOW(a_wr_range, ctl.wr_en, CW'(wr_addr) <= cnt_reg, "write beyond list end")
    // An accepted request always starts a microprogram.
    `SLE_ASSERT_NEXT(a_leave_idle, req_fire, !ctl.idle, "sequencer stayed idle after accept")
    // The length moves by at most one per cycle.
    `SLE_ASSERT_NEXT(a_cnt_step, 1'b1, cnt_reg - $past(cnt_reg) + CW'(1) <= CW'(2), "length jumped")

endmodule

// File: sv/sequential_list_engine.sv
// Top level of the list engine: microcode sequencer driving the list datapath.
//
//   Channel  Dir  Fields                               Handshake
//   req      in   kind, value, position                valid/ready
//   rsp      out  status, count_after, read_value      valid/ready
//
// One request is worked at a time; each takes one microcode step per cycle.
// Append checks for room, then writes at the end; read checks the position, then reads.
// A rejected request sets its status. Delete moves each later entry down a place and
// reverse swaps pairs from both ends, through the store's one read and one write port.
// Reset clears the length and the response valid; the store needs no clearing.
// A stalled response holds the sequencer in its emit step until it is taken.
module sequential_list_engine #(
    parameter int CAPACITY  = sle_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = sle_pkg::DEF_WORD_BITS
) (
    input logic       clk,
    input logic       rst_n,
    sle_in_if.sink    req,
    sle_out_if.source rsp
);
    import sle_pkg::*;

    uword_t    ctl;
    dp_flags_t flags;

    // Sequencer.
    sle_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    // Datapath.
    sle_dp #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .flags (flags),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the list engine: directed table, then phased random requests.
module tb;
    import sle_pkg::*;

    localparam int CAP         = DEF_CAPACITY;
    localparam int WB          = DEF_WORD_BITS;
    localparam int SCRIPT_LEN  = 25;
    localparam int RANDOM_WORDS = 1900;
    localparam int PHASE_WORDS = 160;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 300;

    // One response word as the engine should return it.
    typedef struct packed {
        status_t                     status;
        logic [COUNT_BITS-1:0]       count;
        logic signed [VALUE_BITS-1:0] word;
    } list_reply_t;

    // One row of the directed table; known rows carry their reply typed in.
    typedef struct {
        kind_t                        kind;
        logic signed [VALUE_BITS-1:0] value;
        logic [POS_BITS-1:0]          position;
        bit                           known;
        list_reply_t                  reply;
    } script_row_t;

    typedef enum int {
        MODE_FILL,
        MODE_MIX,
        MODE_DRAIN
    } mix_mode_t;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   mismatch_count;
    int   stall_cycles;

    // Shadow copy of the list.
    logic signed [WB-1:0] list_words [CAP];
    int                   list_len;

    list_reply_t reply_q [$];

    sle_in_if  req_ch();
    sle_out_if rsp_ch();

    sequential_list_engine i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Directed requests: empty list, single entry, extremes of value and
    // position, a position equal to the length, and shifts at the front, middle and end.
    // The full-store case is reached by the fill phases of the random part.
    script_row_t script [SCRIPT_LEN] = '{
        '{KIND_READ,    32'sd0,          7'd0,   1'b1, '{ST_BAD_POS, 8'd0, 32'sd0}},
        '{KIND_DELETE,  32'sd0,          7'd0,   1'b1, '{ST_BAD_POS, 8'd0, 32'sd0}},
        '{KIND_REVERSE, 32'sd0,          7'd0,   1'b1, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_APPEND,  32'sh7FFF_FFFF,  7'd0,   1'b1, '{ST_OK,      8'd1, 32'sd0}},
        '{KIND_REVERSE, 32'sd0,          7'd0,   1'b1, '{ST_OK,      8'd1, 32'sd0}},
        '{KIND_READ,    32'sd0,          7'd1,   1'b1, '{ST_BAD_POS, 8'd1, 32'sd0}},
        '{KIND_APPEND,  32'sh8000_0000,  7'd0,   1'b1, '{ST_OK,      8'd2, 32'sd0}},
        '{KIND_READ,    32'sd0,          7'd0,   1'b1, '{ST_OK,      8'd2, 32'sh7FFF_FFFF}},
        '{KIND_READ,    32'sd0,          7'd1,   1'b1, '{ST_OK,      8'd2, 32'sh8000_0000}},
        '{KIND_READ,    32'sd0,          7'd127, 1'b1, '{ST_BAD_POS, 8'd2, 32'sd0}},
        '{KIND_DELETE,  32'sd0,          7'd2,   1'b1, '{ST_BAD_POS, 8'd2, 32'sd0}},
        '{KIND_DELETE,  32'sd0,          7'd127, 1'b1, '{ST_BAD_POS, 8'd2, 32'sd0}},
        '{KIND_REVERSE, 32'sd0,          7'd0,   1'b1, '{ST_OK,      8'd2, 32'sd0}},
        '{KIND_READ,    32'sd0,          7'd0,   1'b1, '{ST_OK,      8'd2, 32'sh8000_0000}},
        '{KIND_APPEND,  -32'sd1,         7'd0,   1'b0, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_APPEND,  32'sd0,          7'd0,   1'b0, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_APPEND,  32'sh5555_AAAA,  7'd0,   1'b0, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_DELETE,  32'sd0,          7'd1,   1'b0, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_REVERSE, 32'sd0,          7'd0,   1'b0, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_READ,    32'sd0,          7'd3,   1'b0, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_DELETE,  32'sd0,          7'd3,   1'b0, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_DELETE,  32'sd0,          7'd0,   1'b0, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_REVERSE, 32'sd0,          7'd0,   1'b0, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_READ,    32'sd0,          7'd0,   1'b0, '{ST_OK,      8'd0, 32'sd0}},
        '{KIND_READ,    32'sd0,          7'd1,   1'b0, '{ST_OK,      8'd0, 32'sd0}}
    };

    // Apply one request to the shadow list and return the reply it earns.
    function automatic list_reply_t apply_request(kind_t k, logic signed [VALUE_BITS-1:0] v,
                                                  logic [POS_BITS-1:0] p);
        list_reply_t          r;
        logic signed [WB-1:0] held;
        int                   lo;
        int                   hi;
        r.status = ST_OK;
        r.word   = '0;
        case (k)
            KIND_APPEND:
            begin
                if (list_len >= CAP)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    list_words[list_len] = v[WB-1:0];
                    list_len++;
                end
            end
            KIND_DELETE:
            begin
                if (int'(p) >= list_len)
                begin
                    r.status = ST_BAD_POS;
                end
                else
                begin
                    for (int i = int'(p); i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            KIND_REVERSE:
            begin
                lo = 0;
                hi = list_len - 1;
                while (lo < hi)
                begin
                    held           = list_words[lo];
                    list_words[lo] = list_words[hi];
                    list_words[hi] = held;
                    lo++;
                    hi--;
                end
            end
            default:
            begin
                if (int'(p) >= list_len)
                    r.status = ST_BAD_POS;
                else
                    r.word = list_words[p];
            end
        endcase
        r.count = COUNT_BITS'(list_len);
        return r;
    endfunction

    // Present one request word, wait for its handshake, then record its reply.
    task automatic push_request(kind_t k, logic signed [VALUE_BITS-1:0] v,
                                logic [POS_BITS-1:0] p, bit known, list_reply_t typed_reply);
        list_reply_t predicted;
        while (!quiet && $urandom_range(0, 99) < 23)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= k;
        req_ch.value    <= v;
        req_ch.position <= p;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_request(k, v, p);
        reply_q.push_back(known ? typed_reply : predicted);
    endtask

    // Clock.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Response side: check each accepted word, then stall at random.
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (reply_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: response with none pending: status %0d count %0d read %0d",
                             $realtime, rsp_ch.status, rsp_ch.count_after, rsp_ch.read_value);
            end
            else
            begin
                want = reply_q.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.count_after !== want.count ||
                    rsp_ch.read_value !== want.word)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("%0t: response mismatch: expected status %0d count %0d read %0d, ",
                               $realtime, want.status, want.count, want.word);
                        $display("got status %0d count %0d read %0d",
                                 rsp_ch.status, rsp_ch.count_after, rsp_ch.read_value);
                    end
                end
            end
        end
        rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 23);
    end

    // Watchdog: too long without any word moving on either channel.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Reset, directed table, phased random requests, then the final verdict.
    initial
    begin
        int        sent;
        int        phase;
        int        pick;
        mix_mode_t mode;
        kind_t     k;
        logic signed [VALUE_BITS-1:0] v;
        logic [POS_BITS-1:0]          p;

        rst_n           = 1'b0;
        quiet           = 1'b0;
        list_len        = 0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = KIND_APPEND;
        req_ch.value    = '0;
        req_ch.position = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int i = 0; i < SCRIPT_LEN; i++)
            push_request(script[i].kind, script[i].value, script[i].position,
                         script[i].known, script[i].reply);

        // Random phases: fill toward a full store, mixed traffic, drain.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            mode  = mix_mode_t'(phase % 3);
            quiet = (phase == 4);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:
                        k = pick < 88 ? KIND_APPEND : pick < 92 ? KIND_READ :
                            pick < 96 ? KIND_DELETE : KIND_REVERSE;
                    MODE_MIX:
                        k = pick < 35 ? KIND_APPEND : pick < 60 ? KIND_DELETE :
                            pick < 85 ? KIND_READ : KIND_REVERSE;
                    default:
                        k = pick < 15 ? KIND_APPEND : pick < 70 ? KIND_DELETE :
                            pick < 90 ? KIND_READ : KIND_REVERSE;
                endcase
                // Extremes of the word now and then, otherwise any value.
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    v = 32'sh7FFF_FFFF;
                else if (pick < 6)
                    v = 32'sh8000_0000;
                else if (pick < 8)
                    v = -32'sd1;
                else if (pick < 10)
                    v = 32'sd0;
                else
                    v = $urandom;
                // Positions mostly inside the list, some anywhere in the field.
                if (list_len > 0 && $urandom_range(0, 99) < 85)
                    p = POS_BITS'($urandom_range(0, list_len - 1));
                else
                    p = POS_BITS'($urandom_range(0, 127));
                push_request(k, v, p, 1'b0, '0);
                sent++;
            end
            // Now and then hold off the sender until every reply is back.
            if (phase % 4 == 1)
            begin
                req_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (reply_q.size() != 0);
            end
            else
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
            phase++;
        end
        quiet = 1'b0;

        // Wait for the last replies, then a little longer for strays.
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && reply_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/sle_pkg.sv
sv/sle_in_if.sv
sv/sle_out_if.sv
sv/sle_seq.sv
sv/sle_dp.sv
sv/sequential_list_engine.sv
bench/tb.sv
